[hdl/pqem_pkg.sv]
// Shared constants, codes and controller/datapath interface types for the priority queue.
package pqem_pkg;

  localparam int CAPACITY = 16;
  localparam int VALUE_W  = 32;
  localparam int PRI_W    = 16;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int ENTRY_W  = PRI_W + VALUE_W;
  localparam int REQ_W    = 2;
  localparam int STAT_W   = 2;

  localparam logic [REQ_W-1:0] REQ_ENQUEUE = 2'd0;
  localparam logic [REQ_W-1:0] REQ_DEQUEUE = 2'd1;
  localparam logic [REQ_W-1:0] REQ_CLEAR   = 2'd2;

  localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

  // stream widths: input data is value then priority, output adds level and flags
  localparam int S_DATA_W = ((ENTRY_W + 7) / 8) * 8;
  localparam int M_BITS   = ENTRY_W + CNT_W + 2;
  localparam int M_DATA_W = ((M_BITS + 7) / 8) * 8;

  typedef struct packed {
    logic take;        // new request: reset result fields
    logic enq;         // append input entry at tail
    logic enq_full;    // enqueue dropped
    logic clr;         // empty the queue
    logic deq_empty;   // dequeue on empty queue
    logic scan_start;  // walker to entry 0
    logic scan_step;   // read next entry, track best
    logic shift_start; // latch best as result, walker to best + 1
    logic shift_step;  // read next entry, write it one place down
    logic shift_end;   // drop one from the count
    logic load_out;    // move result into output register
  } dp_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic walk_done;
    logic out_free;
  } dp_stat_t;

endpackage

[hdl/pqem_ram.sv]
// Generic single write port RAM with one registered read port.
module pqem_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[hdl/pqem_dp.sv]
// Datapath: entry RAM, fill count, scan/shift walker, best tracking and output register.
module pqem_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [pqem_pkg::S_DATA_W-1:0] s_data_i,
  input  pqem_pkg::dp_cmd_t             cmd_i,
  output pqem_pkg::dp_stat_t            stat_o,
  input  logic                          m_ready_i,
  output logic                          m_valid_o,
  output logic [pqem_pkg::M_DATA_W-1:0] m_data_o,
  output logic [pqem_pkg::STAT_W-1:0]   m_user_o
);

  localparam int AW = pqem_pkg::ADDR_W;
  localparam int CW = pqem_pkg::CNT_W;
  localparam int VW = pqem_pkg::VALUE_W;
  localparam int PW = pqem_pkg::PRI_W;
  localparam int EW = pqem_pkg::ENTRY_W;

  logic [CW-1:0] cnt_q, cnt_d;
  logic [CW-1:0] sc_q, sc_d;
  logic          pv_q, pv_d;
  logic [AW-1:0] pidx_q;
  logic          out_valid_q;

  logic [AW-1:0] best_idx_q;
  logic [VW-1:0] best_val_q;
  logic [PW-1:0] best_pri_q;
  logic [VW-1:0] res_val_q;
  logic [PW-1:0] res_pri_q;
  logic [pqem_pkg::STAT_W-1:0] res_st_q;

  logic [VW-1:0] out_val_q;
  logic [PW-1:0] out_pri_q;
  logic [pqem_pkg::STAT_W-1:0] out_st_q;
  logic [CW-1:0] out_fill_q;
  logic          out_full_q;
  logic          out_empty_q;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [EW-1:0] ram_wdata;
  logic [EW-1:0] ram_rdata;
  logic [VW-1:0] rd_val;
  logic [PW-1:0] rd_pri;
  logic          walk;
  logic          is_full;
  logic          none_held;

  assign rd_val    = ram_rdata[VW-1:0];
  assign rd_pri    = ram_rdata[EW-1:VW];
  assign walk      = cmd_i.scan_step | cmd_i.shift_step;
  assign is_full   = (cnt_q == CW'(pqem_pkg::CAPACITY));
  assign none_held = (cnt_q == '0);

  // shift writes the word read last cycle one place down
  assign ram_we    = cmd_i.enq | (cmd_i.shift_step & pv_q);
  assign ram_waddr = cmd_i.enq ? cnt_q[AW-1:0] : pidx_q - AW'(1);
  assign ram_wdata = cmd_i.enq ? s_data_i[EW-1:0] : ram_rdata;

  pqem_ram #(
    .WIDTH(EW),
    .DEPTH(pqem_pkg::CAPACITY)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(sc_q[AW-1:0]),
    .rdata_o(ram_rdata)
  );

  always_comb begin
    cnt_d = cnt_q;
    sc_d  = sc_q;
    pv_d  = pv_q;
    if (cmd_i.enq) begin
      cnt_d = cnt_q + CW'(1);
    end
    if (cmd_i.clr) begin
      cnt_d = '0;
    end
    if (cmd_i.shift_end) begin
      cnt_d = cnt_q - CW'(1);
    end
    if (cmd_i.scan_start) begin
      sc_d = '0;
      pv_d = 1'b0;
    end
    if (cmd_i.shift_start) begin
      sc_d = CW'(best_idx_q) + CW'(1);
      pv_d = 1'b0;
    end
    if (walk) begin
      if (sc_q < cnt_q) begin
        sc_d = sc_q + CW'(1);
        pv_d = 1'b1;
      end else begin
        pv_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      sc_q        <= '0;
      pv_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      sc_q  <= sc_d;
      pv_q  <= pv_d;
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (m_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (walk) begin
      pidx_q <= sc_q[AW-1:0];
    end
    // strict compare keeps the earliest of equal priorities
    if (cmd_i.scan_step && pv_q) begin
      if (pidx_q == '0 || $signed(rd_pri) > $signed(best_pri_q)) begin
        best_idx_q <= pidx_q;
        best_val_q <= rd_val;
        best_pri_q <= rd_pri;
      end
    end
    if (cmd_i.take) begin
      res_val_q <= '0;
      res_pri_q <= '0;
      res_st_q  <= pqem_pkg::ST_DONE;
    end
    if (cmd_i.enq_full) begin
      res_st_q <= pqem_pkg::ST_FULL;
    end
    if (cmd_i.deq_empty) begin
      res_st_q  <= pqem_pkg::ST_EMPTY;
      res_pri_q <= '1;
    end
    if (cmd_i.shift_start) begin
      res_val_q <= best_val_q;
      res_pri_q <= best_pri_q;
    end
    if (cmd_i.load_out) begin
      out_val_q   <= res_val_q;
      out_pri_q   <= res_pri_q;
      out_st_q    <= res_st_q;
      out_fill_q  <= cnt_q;
      out_full_q  <= is_full;
      out_empty_q <= none_held;
    end
  end

  assign stat_o.full      = is_full;
  assign stat_o.empty     = none_held;
  assign stat_o.walk_done = (sc_q == cnt_q) && !pv_q;
  assign stat_o.out_free  = !out_valid_q || m_ready_i;

  assign m_valid_o = out_valid_q;
  assign m_user_o  = out_st_q;
  assign m_data_o  = pqem_pkg::M_DATA_W'({out_empty_q, out_full_q, out_fill_q,
                                          out_pri_q, out_val_q});

endmodule

[hdl/pqem_ctrl.sv]
// Controller: request decode and sequencing of scan, shift and result hand-off.
module pqem_ctrl (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_valid_i,
  input  logic [pqem_pkg::REQ_W-1:0]  req_i,
  output logic                        s_ready_o,
  input  pqem_pkg::dp_stat_t          stat_i,
  output pqem_pkg::dp_cmd_t           cmd_o
);

  typedef enum logic [1:0] {
    IDLE,
    SCAN,
    SHIFT,
    DONE
  } state_e;

  state_e state_q, state_d;

  assign s_ready_o = (state_q == IDLE);

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    case (state_q)
      IDLE: begin
        if (s_valid_i) begin
          cmd_o.take = 1'b1;
          state_d    = DONE;
          case (req_i)
            pqem_pkg::REQ_ENQUEUE: begin
              if (stat_i.full) begin
                cmd_o.enq_full = 1'b1;
              end else begin
                cmd_o.enq = 1'b1;
              end
            end
            pqem_pkg::REQ_DEQUEUE: begin
              if (stat_i.empty) begin
                cmd_o.deq_empty = 1'b1;
              end else begin
                cmd_o.scan_start = 1'b1;
                state_d          = SCAN;
              end
            end
            pqem_pkg::REQ_CLEAR: begin
              cmd_o.clr = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end
      SCAN: begin
        if (stat_i.walk_done) begin
          cmd_o.shift_start = 1'b1;
          state_d           = SHIFT;
        end else begin
          cmd_o.scan_step = 1'b1;
        end
      end
      SHIFT: begin
        if (stat_i.walk_done) begin
          cmd_o.shift_end = 1'b1;
          state_d         = DONE;
        end else begin
          cmd_o.shift_step = 1'b1;
        end
      end
      DONE: begin
        if (stat_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = IDLE;
        end
      end
      default: begin
        state_d = IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

[hdl/priority_queue_extract_max_core.sv]
// Top level of the bounded max-priority queue with linear scan extraction.
//
//  channel   dir  tdata (low bit up)                          tuser
//  s_axis    in   in_value, in_prio                           req_type
//  m_axis    out  out_value, out_priority, fill_level,        status
//                 full_flag, empty_flag, zero pad
//
// Enqueue, clear and unused codes: accepted in IDLE, then loaded into the output register in DONE.
// Dequeue scans the n held entries one per cycle through the single RAM read port, then
// walks the d entries behind the winner to move them down.
// Reset empties the queue; entry contents are left as they are. A result waits in the
// output register while m_axis stalls; the next word is accepted meanwhile.
module priority_queue_extract_max_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // in_value, in_prio
  input  logic [pqem_pkg::S_DATA_W-1:0] s_axis_tdata_i,
  // req_type
  input  logic [pqem_pkg::REQ_W-1:0]    s_axis_tuser_i,
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // out_value, out_priority, fill_level, full_flag, empty_flag
  output logic [pqem_pkg::M_DATA_W-1:0] m_axis_tdata_o,
  // status
  output logic [pqem_pkg::STAT_W-1:0]   m_axis_tuser_o
);

  pqem_pkg::dp_cmd_t  cmd;
  pqem_pkg::dp_stat_t stat;

  pqem_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .s_valid_i(s_axis_tvalid_i),
    .req_i    (s_axis_tuser_i),
    .s_ready_o(s_axis_tready_o),
    .stat_i   (stat),
    .cmd_o    (cmd)
  );

  pqem_dp u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .s_data_i (s_axis_tdata_i),
    .cmd_i    (cmd),
    .stat_o   (stat),
    .m_ready_i(m_axis_tready_i),
    .m_valid_o(m_axis_tvalid_o),
    .m_data_o (m_axis_tdata_o),
    .m_user_o (m_axis_tuser_o)
  );

endmodule

[hdl/pqem_chk.sv]
// Port-level checker for the priority queue, bound to the top level.
module pqem_chk (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          m_axis_tvalid_o,
  input logic                          m_axis_tready_i,
  input logic [pqem_pkg::M_DATA_W-1:0] m_axis_tdata_o,
  input logic [pqem_pkg::STAT_W-1:0]   m_axis_tuser_o
);

  localparam int VW = pqem_pkg::VALUE_W;
  localparam int PW = pqem_pkg::PRI_W;
  localparam int CW = pqem_pkg::CNT_W;
  localparam int FL = pqem_pkg::ENTRY_W;

  logic [CW-1:0] fill;
  logic          full_f;
  logic          empty_f;
  logic [VW-1:0] val;
  logic [PW-1:0] pri;

  assign val     = m_axis_tdata_o[VW-1:0];
  assign pri     = m_axis_tdata_o[FL-1:VW];
  assign fill    = m_axis_tdata_o[FL+CW-1:FL];
  assign full_f  = m_axis_tdata_o[FL+CW];
  assign empty_f = m_axis_tdata_o[FL+CW+1];

  a_fill_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> fill <= CW'(pqem_pkg::CAPACITY))
    else $error("fill level above capacity");

  a_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (full_f == (fill == CW'(pqem_pkg::CAPACITY)))
                        && (empty_f == (fill == '0)))
    else $error("full/empty flags disagree with fill level");

  a_empty_deq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o == pqem_pkg::ST_EMPTY
      |-> val == '0 && pri == '1 && empty_f)
    else $error("dequeue on empty queue returned wrong word");

  a_full_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o == pqem_pkg::ST_FULL
      |-> full_f && val == '0 && pri == '0)
    else $error("dropped enqueue reported without full queue");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i
      |=> m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("stalled output word changed");

endmodule

bind priority_queue_extract_max_core pqem_chk u_pqem_chk (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .m_axis_tvalid_o(m_axis_tvalid_o),
  .m_axis_tready_i(m_axis_tready_i),
  .m_axis_tdata_o (m_axis_tdata_o),
  .m_axis_tuser_o (m_axis_tuser_o)
);

[test/priority_queue_extract_max_core_tb.sv]
// Self-checking stream testbench for the max-priority queue core.
module priority_queue_extract_max_core_tb;
  import pqem_pkg::*;

  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
  localparam int LIMIT_CYCLES = 1_000_000;
  localparam int TAIL_CYCLES  = 2 * CAPACITY + 20;
  localparam int RANDOM_ITEMS = 1300;

  // result word layout, low bit up
  localparam int PRI_LSB   = VALUE_W;
  localparam int LVL_LSB   = VALUE_W + PRI_W;
  localparam int FULL_BIT  = LVL_LSB + CNT_W;
  localparam int EMPTY_BIT = FULL_BIT + 1;

  typedef struct {
    logic [REQ_W-1:0]          kind;
    logic [VALUE_W-1:0]        value;
    logic signed [PRI_W-1:0]   prio;
    bit                        hold;  // wait for all results before sending
  } request_t;

  typedef struct packed {
    logic [VALUE_W-1:0]        value;
    logic signed [PRI_W-1:0]   prio;
    logic [STAT_W-1:0]         status;
    logic [CNT_W-1:0]          level;
    logic                      full;
    logic                      empty;
  } outcome_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_valid = 1'b0;
  logic                s_ready;
  logic [S_DATA_W-1:0] s_data = '0;
  logic [REQ_W-1:0]    s_user = REQ_ENQUEUE;
  logic                m_valid;
  logic                m_ready = 1'b0;
  logic [M_DATA_W-1:0] m_data;
  logic [STAT_W-1:0]   m_user;

  priority_queue_extract_max_core i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_user),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),
    .m_axis_tuser_o  (m_user)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // shadow copy of the queue contents, in arrival order
  logic [VALUE_W-1:0]      shadow_val [CAPACITY];
  logic signed [PRI_W-1:0] shadow_pri [CAPACITY];
  int                      shadow_count = 0;

  request_t pending_q [$];
  outcome_t outcome_q [$];
  request_t in_flight;
  int       send_gap = 0;
  int       stall_left = 0;
  int       mismatches = 0;
  int       results_seen = 0;
  int       cycle_cnt = 0;
  bit       calm = 1'b0;

  function automatic outcome_t serve_request(request_t rq);
    outcome_t o;
    int best;
    o = '0;
    o.status = ST_DONE;
    case (rq.kind)
      REQ_ENQUEUE: begin
        if (shadow_count == CAPACITY) begin
          o.status = ST_FULL;
        end else begin
          shadow_val[shadow_count] = rq.value;
          shadow_pri[shadow_count] = rq.prio;
          shadow_count++;
        end
      end
      REQ_DEQUEUE: begin
        if (shadow_count == 0) begin
          o.status = ST_EMPTY;
          o.prio = -16'sd1;
        end else begin
          best = 0;
          // strict compare keeps the earliest arrival on a tie
          for (int i = 1; i < shadow_count; i++)
            if (shadow_pri[i] > shadow_pri[best]) best = i;
          o.value = shadow_val[best];
          o.prio = shadow_pri[best];
          for (int i = best + 1; i < shadow_count; i++) begin
            shadow_val[i-1] = shadow_val[i];
            shadow_pri[i-1] = shadow_pri[i];
          end
          shadow_count--;
        end
      end
      REQ_CLEAR: shadow_count = 0;
      default: ;
    endcase
    o.level = CNT_W'(shadow_count);
    o.full = (shadow_count == CAPACITY);
    o.empty = (shadow_count == 0);
    return o;
  endfunction

  // mostly back to back, some short gaps, a few long ones
  function automatic int pick_idle(bit quiet);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic signed [PRI_W-1:0] pick_priority();
    int unsigned r;
    logic signed [PRI_W-1:0] p;
    r = $urandom_range(0, 9);
    if (r < 5) begin
      // narrow band to force ties
      p = PRI_W'($urandom_range(0, 8));
      p = p - 16'sd4;
    end else if (r == 5) begin
      p = 16'sh7fff;
    end else if (r == 6) begin
      p = 16'sh8000;
    end else begin
      p = PRI_W'($urandom);
    end
    return p;
  endfunction

  task automatic add_request(logic [REQ_W-1:0] kind, logic [VALUE_W-1:0] value,
                             logic signed [PRI_W-1:0] prio, bit hold);
    request_t rq;
    rq.kind = kind;
    rq.value = value;
    rq.prio = prio;
    rq.hold = hold;
    pending_q.push_back(rq);
  endtask

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("MISMATCH result %0d %s: got 0x%0h want 0x%0h", results_seen, what, got, want);
    mismatches++;
  endtask

  task automatic check_field(string what, logic [63:0] got, logic [63:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt % 256 == 0) calm <= ($urandom_range(0, 3) == 0);
  end

  // sender
  always @(posedge clk_i or negedge rst_ni) begin
    request_t nxt;
    bit busy;
    if (!rst_ni) begin
      s_valid <= 1'b0;
      s_data <= '0;
      s_user <= REQ_ENQUEUE;
    end else begin
      busy = s_valid;
      if (s_valid && s_ready) begin
        outcome_q.push_back(serve_request(in_flight));
        busy = 1'b0;
        send_gap = pick_idle(calm);
      end
      if (!busy) begin
        if (send_gap > 0) begin
          send_gap--;
          s_valid <= 1'b0;
        end else if (pending_q.size() != 0 &&
                     !(pending_q[0].hold && outcome_q.size() != 0)) begin
          nxt = pending_q.pop_front();
          in_flight = nxt;
          s_valid <= 1'b1;
          s_data <= S_DATA_W'({nxt.prio, nxt.value});
          s_user <= nxt.kind;
        end else begin
          s_valid <= 1'b0;
        end
      end
    end
  end

  // receiver and checker
  always @(posedge clk_i or negedge rst_ni) begin
    outcome_t want;
    if (!rst_ni) begin
      m_ready <= 1'b0;
    end else begin
      if (m_valid && m_ready) begin
        if (outcome_q.size() == 0) begin
          report_mismatch("word with nothing expected", 64'(m_data), 64'd0);
        end else begin
          want = outcome_q.pop_front();
          check_field("value", 64'(m_data[VALUE_W-1:0]), 64'(want.value));
          check_field("priority", 64'(m_data[PRI_LSB +: PRI_W]), 64'(unsigned'(want.prio)));
          check_field("status", 64'(m_user), 64'(want.status));
          check_field("fill level", 64'(m_data[LVL_LSB +: CNT_W]), 64'(want.level));
          check_field("full flag", 64'(m_data[FULL_BIT]), 64'(want.full));
          check_field("empty flag", 64'(m_data[EMPTY_BIT]), 64'(want.empty));
          check_field("pad", 64'(m_data[M_DATA_W-1:EMPTY_BIT+1]), 64'd0);
        end
        results_seen++;
      end
      if (stall_left > 0) begin
        stall_left--;
        m_ready <= 1'b0;
      end else begin
        m_ready <= 1'b1;
        stall_left = pick_idle(calm);
      end
    end
  end

  initial begin
    int generated;
    int run_len;
    int unsigned r;
    bit fill_mode;
    logic [REQ_W-1:0] kind;

    // directed: empty dequeue, unused code, extremes, tie order, clear, overflow
    add_request(REQ_DEQUEUE, 32'hdead_beef, 16'sd5, 1'b0);
    add_request(REQ_UNUSED, 32'h1234_5678, -16'sd7, 1'b0);
    add_request(REQ_ENQUEUE, 32'h0000_0000, 16'sd0, 1'b0);
    add_request(REQ_ENQUEUE, 32'hffff_ffff, 16'sh7fff, 1'b0);
    add_request(REQ_ENQUEUE, 32'h0000_0001, 16'sh8000, 1'b0);
    add_request(REQ_ENQUEUE, 32'h0000_0002, 16'sh7fff, 1'b0);
    add_request(REQ_DEQUEUE, 32'hffff_ffff, 16'shffff, 1'b0);
    add_request(REQ_DEQUEUE, 32'h0, 16'sh0, 1'b0);
    add_request(REQ_CLEAR, 32'h5555_aaaa, 16'sh5a5a, 1'b0);
    add_request(REQ_DEQUEUE, 32'h0, 16'sh0, 1'b0);
    for (int i = 0; i < CAPACITY; i++)
      add_request(REQ_ENQUEUE, $urandom, pick_priority(), 1'b0);
    add_request(REQ_ENQUEUE, 32'haaaa_5555, 16'sh7fff, 1'b0);
    add_request(REQ_UNUSED, 32'hffff_ffff, 16'shffff, 1'b0);

    // random: runs that are fill-heavy or drain-heavy, chosen at random
    generated = 0;
    while (generated < RANDOM_ITEMS) begin
      fill_mode = $urandom_range(0, 1);
      run_len = $urandom_range(20, 60);
      for (int k = 0; k < run_len; k++) begin
        r = $urandom_range(0, 99);
        if (r < 2) kind = REQ_CLEAR;
        else if (r < 4) kind = REQ_UNUSED;
        else if (r < (fill_mode ? 76 : 30)) kind = REQ_ENQUEUE;
        else kind = REQ_DEQUEUE;
        add_request(kind, $urandom, pick_priority(), generated == 400 || generated == 950);
        generated++;
      end
    end

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (!(pending_q.size() == 0 && !s_valid && outcome_q.size() == 0) &&
           cycle_cnt < LIMIT_CYCLES)
      @(posedge clk_i);
    if (cycle_cnt >= LIMIT_CYCLES) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("CHECKS FAILED");
    end else begin
      repeat (TAIL_CYCLES) @(posedge clk_i);
      if (outcome_q.size() != 0)
        report_mismatch("expected words left over", 64'(outcome_q.size()), 64'd0);
      if (mismatches == 0) begin
        $display("ALL CHECKS PASSED");
      end else begin
        $display("CHECKS FAILED");
      end
    end
    $finish;
  end

endmodule

[files.f]
hdl/pqem_pkg.sv
hdl/pqem_ram.sv
hdl/pqem_dp.sv
hdl/pqem_ctrl.sv
hdl/priority_queue_extract_max_core.sv
hdl/pqem_chk.sv
test/priority_queue_extract_max_core_tb.sv
